[rtl/aaes_pkg.sv]
// Package for the alcohol absorption and elimination step unit.
// Holds the sequencer states, register indexes, field widths and reset values.
// No dependencies.
package aaes_pkg;

  localparam int unsigned STORE_W     = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned BURN_W      = 20;
  localparam int unsigned INV_W       = 24;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned SWALLOW_W   = 24;
  localparam int unsigned LEVEL_W     = 20;
  localparam int unsigned EXPOSURE_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 72;
  localparam int unsigned OUT_USER_W  = 2;

  localparam int unsigned MUL_A_W     = 32;
  localparam int unsigned MUL_B_W     = 24;
  localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W   = $clog2(MUL_B_W);

  localparam logic [FRAC_W-1:0] ABSORB_RESET = FRAC_W'(4227);
  localparam logic [BURN_W-1:0] BURN_RESET   = BURN_W'(8192);
  localparam logic [INV_W-1:0]  INV_RESET    = INV_W'(335544);
  localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(655);

  localparam logic [CFG_ADDR_W-1:0] CFG_ABSORB = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BURN   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INV    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_THR    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_M1GO,
    ST_M1WAIT,
    ST_ABSORB,
    ST_BURN,
    ST_M2GO,
    ST_M2WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

[rtl/aaes_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on aaes_pkg for widths and the request and status structs.
module aaes_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  aaes_pkg::mul_req_t            req,
  output aaes_pkg::mul_status_t         status,
  output logic [aaes_pkg::MUL_P_W-1:0]  product
);

  logic [aaes_pkg::MUL_A_W-1:0]   a_reg;
  logic [aaes_pkg::MUL_A_W-1:0]   hi;
  logic [aaes_pkg::MUL_B_W-1:0]   lo;
  logic [aaes_pkg::MUL_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [aaes_pkg::MUL_A_W:0]     sum;

  assign sum = lo[0] ? ({1'b0, hi} + {1'b0, a_reg}) : {1'b0, hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == aaes_pkg::MUL_CNT_W'(aaes_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      hi    <= '0;
      lo    <= req.b;
    end else if (busy) begin
      hi <= sum[aaes_pkg::MUL_A_W:1];
      lo <= {sum[0], lo[aaes_pkg::MUL_B_W-1:1]};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign product     = {hi, lo};

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    status.done |-> $past(busy))
    else $error("multiplier done without a running product");

endmodule

[rtl/alcohol_absorption_elimination_step_unit.sv]
// Top level of the alcohol absorption and elimination step unit.
// Depends on aaes_pkg and on aaes_mul, the shared serial multiplier.
//
// Channel   Direction  Contents
// s_*       in         tdata: swallowed_grams; tuser: restart
// m_*       out        tdata: level, episode_peak, episode_exposure; tlast: episode_end;
//                      tuser: in_episode, settled
// cfg_*     in         register index and data, written when cfg_we is high
//
// Each step runs two passes of the shared shift-and-add multiplier.
// The input is ready only while the sequencer is idle.
// A finished result waits in the output register; the next step may run meanwhile
// and holds in its last state until that register is free.
// Reset is synchronous; it clears the stores, the stretch tracking and the output valid, and loads the config defaults.
module alcohol_absorption_elimination_step_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [aaes_pkg::IN_DATA_W-1:0]    s_tdata,   // [23:0] swallowed_grams
  input  logic                              s_tuser,   // [0] restart
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [aaes_pkg::OUT_DATA_W-1:0]   m_tdata,   // [19:0] level, [39:20] episode_peak,
                                                       // [71:40] episode_exposure
  output logic [aaes_pkg::OUT_USER_W-1:0]   m_tuser,   // [0] in_episode, [1] settled
  output logic                              m_tlast,   // episode_end
  input  logic                              cfg_we,
  input  logic [aaes_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [aaes_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  aaes_pkg::state_t state, state_next;

  logic [aaes_pkg::FRAC_W-1:0]     absorb_fraction;
  logic [aaes_pkg::BURN_W-1:0]     burn_per_step;
  logic [aaes_pkg::INV_W-1:0]      inv_distribution;
  logic [aaes_pkg::THR_W-1:0]      empty_threshold;

  logic [aaes_pkg::SWALLOW_W-1:0]  swallowed;
  logic                            restart;

  logic [aaes_pkg::STORE_W-1:0]    stomach;
  logic [aaes_pkg::STORE_W-1:0]    body;
  logic                            active;
  logic [aaes_pkg::LEVEL_W-1:0]    peak;
  logic [aaes_pkg::EXPOSURE_W-1:0] exposure;

  aaes_pkg::mul_req_t              mul_req;
  aaes_pkg::mul_status_t           mul_st;
  logic [aaes_pkg::MUL_P_W-1:0]    product;

  logic                            accept;
  logic                            out_free;
  logic                            res_load;

  logic [aaes_pkg::STORE_W:0]      stomach_sum;
  logic [aaes_pkg::STORE_W-1:0]    absorbed;
  logic [aaes_pkg::STORE_W:0]      body_sum;
  logic [aaes_pkg::LEVEL_W-1:0]    level;
  logic                            level_pos;
  logic [aaes_pkg::LEVEL_W-1:0]    peak_base;
  logic [aaes_pkg::EXPOSURE_W-1:0] exp_base;
  logic [aaes_pkg::EXPOSURE_W:0]   exp_sum;
  logic                            active_next;
  logic [aaes_pkg::LEVEL_W-1:0]    peak_next;
  logic [aaes_pkg::EXPOSURE_W-1:0] exposure_next;
  logic                            ended;
  logic                            settled;

  aaes_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .status  (mul_st),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      absorb_fraction  <= aaes_pkg::ABSORB_RESET;
      burn_per_step    <= aaes_pkg::BURN_RESET;
      inv_distribution <= aaes_pkg::INV_RESET;
      empty_threshold  <= aaes_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        aaes_pkg::CFG_ABSORB: absorb_fraction  <= cfg_wdata[aaes_pkg::FRAC_W-1:0];
        aaes_pkg::CFG_BURN:   burn_per_step    <= cfg_wdata[aaes_pkg::BURN_W-1:0];
        aaes_pkg::CFG_INV:    inv_distribution <= cfg_wdata[aaes_pkg::INV_W-1:0];
        aaes_pkg::CFG_THR:    empty_threshold  <= cfg_wdata[aaes_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      aaes_pkg::ST_IDLE:   if (s_tvalid) state_next = aaes_pkg::ST_LOAD;
      aaes_pkg::ST_LOAD:   state_next = aaes_pkg::ST_M1GO;
      aaes_pkg::ST_M1GO:   state_next = aaes_pkg::ST_M1WAIT;
      aaes_pkg::ST_M1WAIT: if (mul_st.done) state_next = aaes_pkg::ST_ABSORB;
      aaes_pkg::ST_ABSORB: state_next = aaes_pkg::ST_BURN;
      aaes_pkg::ST_BURN:   state_next = aaes_pkg::ST_M2GO;
      aaes_pkg::ST_M2GO:   state_next = aaes_pkg::ST_M2WAIT;
      aaes_pkg::ST_M2WAIT: if (mul_st.done) state_next = aaes_pkg::ST_FINISH;
      aaes_pkg::ST_FINISH: if (out_free) state_next = aaes_pkg::ST_IDLE;
      default:             state_next = aaes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    res_load      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = stomach;
    mul_req.b     = {{(aaes_pkg::MUL_B_W - aaes_pkg::FRAC_W){1'b0}}, absorb_fraction};
    unique case (state)
      aaes_pkg::ST_IDLE:   s_tready = 1'b1;
      aaes_pkg::ST_M1GO:   mul_req.start = 1'b1;
      aaes_pkg::ST_M2GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = body;
        mul_req.b     = inv_distribution;
      end
      aaes_pkg::ST_FINISH: res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aaes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      swallowed <= s_tdata[aaes_pkg::SWALLOW_W-1:0];
      restart   <= s_tuser;
    end
  end

  assign stomach_sum = {1'b0, (restart ? '0 : stomach)} + {8'd0, swallowed};
  assign absorbed    = product[aaes_pkg::STORE_W+aaes_pkg::FRAC_W-1:aaes_pkg::FRAC_W];
  assign body_sum    = {1'b0, body} + {1'b0, absorbed};

  assign level = (|product[aaes_pkg::MUL_P_W-1:aaes_pkg::INV_W+aaes_pkg::LEVEL_W])
               ? {aaes_pkg::LEVEL_W{1'b1}}
               : product[aaes_pkg::INV_W+aaes_pkg::LEVEL_W-1:aaes_pkg::INV_W];
  assign level_pos = |level;
  assign peak_base = active ? peak : '0;
  assign exp_base  = active ? exposure : '0;
  assign exp_sum   = {1'b0, exp_base} + {{(aaes_pkg::EXPOSURE_W + 1 - aaes_pkg::LEVEL_W){1'b0}},
                                         level};

  always_comb begin
    active_next   = active;
    peak_next     = peak;
    exposure_next = exposure;
    ended         = 1'b0;
    if (level_pos) begin
      active_next   = 1'b1;
      peak_next     = (level > peak_base) ? level : peak_base;
      exposure_next = exp_sum[aaes_pkg::EXPOSURE_W] ? {aaes_pkg::EXPOSURE_W{1'b1}}
                                                    : exp_sum[aaes_pkg::EXPOSURE_W-1:0];
    end else if (active) begin
      active_next = 1'b0;
      ended       = 1'b1;
    end
  end

  assign settled = (body == '0) && (stomach < {16'd0, empty_threshold});

  always_ff @(posedge clk) begin
    if (rst) begin
      stomach  <= '0;
      body     <= '0;
      active   <= 1'b0;
      peak     <= '0;
      exposure <= '0;
    end else begin
      unique case (state)
        aaes_pkg::ST_LOAD: begin
          stomach <= stomach_sum[aaes_pkg::STORE_W] ? {aaes_pkg::STORE_W{1'b1}}
                                                    : stomach_sum[aaes_pkg::STORE_W-1:0];
          if (restart) begin
            body     <= '0;
            active   <= 1'b0;
            peak     <= '0;
            exposure <= '0;
          end
        end
        aaes_pkg::ST_ABSORB: begin
          stomach <= stomach - absorbed;
          body    <= body_sum[aaes_pkg::STORE_W] ? {aaes_pkg::STORE_W{1'b1}}
                                                 : body_sum[aaes_pkg::STORE_W-1:0];
        end
        aaes_pkg::ST_BURN: begin
          body <= ({12'd0, burn_per_step} >= body) ? '0 : body - {12'd0, burn_per_step};
        end
        aaes_pkg::ST_FINISH: begin
          if (out_free) begin
            active   <= active_next;
            peak     <= peak_next;
            exposure <= exposure_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {exposure_next, peak_next, level};
      m_tuser <= {settled, level_pos};
      m_tlast <= ended;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == aaes_pkg::ST_LOAD)
    else $error("accepted transaction did not start the sequencer");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |-> (state == aaes_pkg::ST_M1WAIT || state == aaes_pkg::ST_M2WAIT))
    else $error("multiplier finished outside a wait state");

  a_episode_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tdata[aaes_pkg::LEVEL_W-1:0] != '0)))
    else $error("in_episode disagrees with level");

  a_end_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[aaes_pkg::LEVEL_W-1:0] == '0 && !m_tuser[0]))
    else $error("episode end with a positive level");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[2*aaes_pkg::LEVEL_W-1:aaes_pkg::LEVEL_W] >= m_tdata[aaes_pkg::LEVEL_W-1:0]))
    else $error("peak below the current level");

endmodule
